// ----- src/gppt_pkg.sv -----
package gppt_pkg;

   localparam int TIME_MAX_DEF = 255;

   localparam int TEMP_W     = 9;
   localparam int RPM_W      = 14;
   localparam int THR_W      = 7;
   localparam int SEC_W      = 8;
   localparam int VLOW_W     = 8;
   localparam int OUT_CNT_W  = 9;
   localparam int PROD_W     = SEC_W + TEMP_W;
   localparam int DIV_STEPS  = PROD_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GLOW_THRESHOLD = 3'd0,
      REG_MAX_GLOW       = 3'd1,
      REG_VERY_LOW       = 3'd2,
      REG_MAX_LAMP       = 3'd3,
      REG_MIN_LAMP       = 3'd4,
      REG_COLD_ENGINE    = 3'd5,
      REG_MIN_RPM        = 3'd6
   } csr_index_type;

   typedef enum logic {
      KIND_START   = 1'b0,
      KIND_PROCESS = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SAT,
      ST_PICK,
      ST_APPLY
   } state_type;

   localparam logic [THR_W-1:0]  THR_RESET      = 7'd10;
   localparam logic [SEC_W-1:0]  MAX_GLOW_RESET = 8'd30;
   localparam logic [VLOW_W-1:0] VERY_LOW_RESET = 8'hEC;
   localparam logic [SEC_W-1:0]  MAX_LAMP_RESET = 8'd10;
   localparam logic [SEC_W-1:0]  MIN_LAMP_RESET = 8'd1;
   localparam logic [TEMP_W-1:0] COLD_RESET     = 9'd30;
   localparam logic [RPM_W-1:0]  MIN_RPM_RESET  = 14'd400;

endpackage

// ----- src/glow_plug_preheat_timer.sv -----
// An accepted word goes through ST_PICK and ST_APPLY into the result register; the glow
// time adds ST_MUL, ST_DIV and ST_SAT before ST_PICK, and the lamp time runs them again.
// ST_APPLY holds while a result is not taken. A new word is taken only back in ST_IDLE.
// Both times use the shared 17-step restoring divider behind one 8x9 multiplier.
// Reset is synchronous: setting registers return to their defaults, counters and drives clear,
// and the block takes words in the first cycle after reset.
module glow_plug_preheat_timer #(
   parameter int TIME_MAX = gppt_pkg::TIME_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // coolant_temp [8:0], engine_rpm [22:9], second_tick [23]
   input  logic [gppt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // plug_on [0], lamp_on [1], heating [2], glow_seconds_left [11:3],
   // lamp_seconds_left [20:12], zero fill [23:21]
   output logic [gppt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gppt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gppt_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int TW = $clog2(TIME_MAX + 1);
   localparam int CW = TW + 1;

   localparam int PW = gppt_pkg::PROD_W;
   localparam int SW = gppt_pkg::SEC_W;
   localparam int TPW = gppt_pkg::TEMP_W;

   gppt_pkg::state_type state_ff, state_in;

   logic [gppt_pkg::THR_W-1:0]         thr_ff;
   logic [SW-1:0]                      max_glow_ff, max_lamp_ff, min_lamp_ff;
   logic signed [gppt_pkg::VLOW_W-1:0] very_low_ff;
   logic signed [TPW-1:0]              cold_ff;
   logic [gppt_pkg::RPM_W-1:0]         min_rpm_ff;

   logic                   kind_ff, kind_in;
   logic signed [TPW-1:0]  temp_ff, temp_in;
   logic                   tick_ff, tick_in;
   logic                   post_ff, post_in;
   logic                   phase_ff, phase_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [gppt_pkg::THR_W-1:0] rem_ff, rem_in;
   logic [gppt_pkg::STEP_W-1:0] step_ff, step_in;
   logic [TW-1:0]          glow_t_ff, glow_t_in, lamp_t_ff, lamp_t_in;

   logic signed [CW-1:0]   glow_cnt_ff, glow_cnt_in, lamp_cnt_ff, lamp_cnt_in;
   logic                   started_ff, started_in, warm_ff, warm_in;
   logic                   plug_ff, plug_in, lamp_ff, lamp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [gppt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [TPW-1:0]  req_temp, thr_s, very_low_s;
   logic signed [TPW:0]    diff_full;
   logic [gppt_pkg::RPM_W-1:0] req_rpm;
   logic [TPW-1:0]         diff_mag;
   logic [SW-1:0]          mul_a;
   logic [PW-1:0]          mul_res, quot;
   logic [SW:0]            div_shift;
   logic                   div_ge;
   logic                   req_accept, warm_now, post_now, temp_below;

   function automatic logic [TW-1:0] sat_time(input logic [PW-1:0] v);
      if (v > PW'(TIME_MAX)) begin
         return TW'(TIME_MAX);
      end
      return v[TW-1:0];
   endfunction

   assign req_temp   = req_tdata[TPW-1:0];
   assign req_rpm    = req_tdata[TPW+gppt_pkg::RPM_W-1:TPW];
   assign thr_s      = signed'({2'b00, thr_ff});
   assign very_low_s = TPW'(very_low_ff);
   assign req_accept = req_tvalid && req_tready;

   assign req_tready = (state_ff == gppt_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign diff_full = (TPW+1)'(thr_s) - (TPW+1)'(temp_ff);
   assign diff_mag  = diff_full[TPW-1:0];
   assign mul_a     = phase_ff ? max_lamp_ff : max_glow_ff;
   assign mul_res   = mul_a * diff_mag;
   assign div_shift = {rem_ff, prod_ff[PW-1]};
   assign div_ge    = div_shift >= {1'b0, thr_ff};
   assign quot      = phase_ff ? (prod_ff >> 1) : prod_ff;

   assign warm_now   = warm_ff || (req_temp > cold_ff);
   assign post_now   = !warm_now && (req_rpm > min_rpm_ff);
   assign temp_below = req_temp < thr_s;

   always_comb begin
      logic signed [CW-1:0] gc, lc;
      logic signed [CW-1:0] glow_t_s;
      logic                 warm_v, plug_v, lamp_v;

      state_in     = state_ff;
      kind_in      = kind_ff;
      temp_in      = temp_ff;
      tick_in      = tick_ff;
      post_in      = post_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      glow_t_in    = glow_t_ff;
      lamp_t_in    = lamp_t_ff;
      glow_cnt_in  = glow_cnt_ff;
      lamp_cnt_in  = lamp_cnt_ff;
      started_in   = started_ff;
      warm_in      = warm_ff;
      plug_in      = plug_ff;
      lamp_in      = lamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      gc       = glow_cnt_ff;
      lc       = lamp_cnt_ff;
      glow_t_s = signed'({1'b0, glow_t_ff});
      warm_v   = warm_ff;
      plug_v   = plug_ff;
      lamp_v   = lamp_ff;

      unique case (state_ff)
         gppt_pkg::ST_IDLE: begin
            if (req_accept) begin
               kind_in   = req_tuser;
               temp_in   = req_temp;
               tick_in   = req_tdata[TPW+gppt_pkg::RPM_W];
               phase_in  = 1'b0;
               glow_t_in = '0;
               post_in   = 1'b0;
               state_in  = gppt_pkg::ST_PICK;
               if (gppt_pkg::kind_type'(req_tuser) == gppt_pkg::KIND_START) begin
                  if (temp_below) begin
                     state_in = gppt_pkg::ST_MUL;
                  end
               end else if (started_ff) begin
                  post_in = post_now;
                  if (post_now && temp_below) begin
                     state_in = gppt_pkg::ST_MUL;
                  end
               end
            end
         end
         gppt_pkg::ST_MUL: begin
            prod_in  = mul_res;
            rem_in   = '0;
            step_in  = '0;
            state_in = gppt_pkg::ST_DIV;
         end
         gppt_pkg::ST_DIV: begin
            rem_in  = div_ge ? gppt_pkg::THR_W'(div_shift - {1'b0, thr_ff})
                             : div_shift[gppt_pkg::THR_W-1:0];
            prod_in = {prod_ff[PW-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == gppt_pkg::STEP_W'(gppt_pkg::DIV_STEPS - 1)) begin
               state_in = gppt_pkg::ST_SAT;
            end
         end
         gppt_pkg::ST_SAT: begin
            if (phase_ff) begin
               lamp_t_in = (thr_ff == '0) ? TW'(TIME_MAX) : sat_time(quot);
               state_in  = gppt_pkg::ST_APPLY;
            end else begin
               glow_t_in = (thr_ff == '0) ? TW'(TIME_MAX) : sat_time(quot);
               state_in  = gppt_pkg::ST_PICK;
            end
         end
         gppt_pkg::ST_PICK: begin
            state_in = gppt_pkg::ST_APPLY;
            if (gppt_pkg::kind_type'(kind_ff) == gppt_pkg::KIND_START && glow_t_ff != '0) begin
               if (temp_ff <= very_low_s) begin
                  lamp_t_in = sat_time(PW'(max_lamp_ff));
               end else if (temp_ff < thr_s) begin
                  phase_in = 1'b1;
                  state_in = gppt_pkg::ST_MUL;
               end else begin
                  lamp_t_in = sat_time(PW'(min_lamp_ff));
               end
            end
         end
         gppt_pkg::ST_APPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (gppt_pkg::kind_type'(kind_ff) == gppt_pkg::KIND_START) begin
                  gc = glow_t_s;
                  if (glow_t_ff != '0) begin
                     plug_v = 1'b1;
                     lamp_v = 1'b1;
                     lc     = signed'({1'b0, lamp_t_ff});
                  end
                  started_in = 1'b1;
               end else if (started_ff) begin
                  if (temp_ff > cold_ff) begin
                     warm_v = 1'b1;
                  end
                  if (post_ff) begin
                     gc = glow_t_s;
                     if (glow_t_ff != '0) begin
                        plug_v = 1'b1;
                        warm_v = 1'b1;
                     end
                  end
                  if (tick_ff && gc >= 0) begin
                     if (gc <= 0) begin
                        plug_v = 1'b0;
                     end
                     gc = gc - CW'(1);
                     if (lc >= 0) begin
                        if (lc <= 0) begin
                           lamp_v = 1'b0;
                        end
                        lc = lc - CW'(1);
                     end
                  end
               end
               glow_cnt_in  = gc;
               lamp_cnt_in  = lc;
               warm_in      = warm_v;
               plug_in      = plug_v;
               lamp_in      = lamp_v;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000,
                               gppt_pkg::OUT_CNT_W'(lc),
                               gppt_pkg::OUT_CNT_W'(gc),
                               gc > 0, lamp_v, plug_v};
               state_in     = gppt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gppt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gppt_pkg::ST_IDLE;
         glow_cnt_ff  <= '0;
         lamp_cnt_ff  <= '0;
         started_ff   <= 1'b0;
         warm_ff      <= 1'b0;
         plug_ff      <= 1'b0;
         lamp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         glow_cnt_ff  <= glow_cnt_in;
         lamp_cnt_ff  <= lamp_cnt_in;
         started_ff   <= started_in;
         warm_ff      <= warm_in;
         plug_ff      <= plug_in;
         lamp_ff      <= lamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      temp_ff     <= temp_in;
      tick_ff     <= tick_in;
      post_ff     <= post_in;
      phase_ff    <= phase_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      glow_t_ff   <= glow_t_in;
      lamp_t_ff   <= lamp_t_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= gppt_pkg::THR_RESET;
         max_glow_ff <= gppt_pkg::MAX_GLOW_RESET;
         very_low_ff <= gppt_pkg::VERY_LOW_RESET;
         max_lamp_ff <= gppt_pkg::MAX_LAMP_RESET;
         min_lamp_ff <= gppt_pkg::MIN_LAMP_RESET;
         cold_ff     <= gppt_pkg::COLD_RESET;
         min_rpm_ff  <= gppt_pkg::MIN_RPM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (gppt_pkg::csr_index_type'(csr_index))
            gppt_pkg::REG_GLOW_THRESHOLD: thr_ff      <= csr_data[gppt_pkg::THR_W-1:0];
            gppt_pkg::REG_MAX_GLOW:       max_glow_ff <= csr_data[SW-1:0];
            gppt_pkg::REG_VERY_LOW:       very_low_ff <= csr_data[gppt_pkg::VLOW_W-1:0];
            gppt_pkg::REG_MAX_LAMP:       max_lamp_ff <= csr_data[SW-1:0];
            gppt_pkg::REG_MIN_LAMP:       min_lamp_ff <= csr_data[SW-1:0];
            gppt_pkg::REG_COLD_ENGINE:    cold_ff     <= csr_data[TPW-1:0];
            gppt_pkg::REG_MIN_RPM:        min_rpm_ff  <= csr_data[gppt_pkg::RPM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A running glow countdown always has its plug driven, and likewise for the lamp.
   a_glow_implies_plug: assert property (@(posedge clock) disable iff (reset)
      (glow_cnt_ff > 0) |-> plug_ff)
      else $error("glow countdown running with plug off");

   a_lamp_implies_drive: assert property (@(posedge clock) disable iff (reset)
      (lamp_cnt_ff > 0) |-> lamp_ff)
      else $error("lamp countdown running with lamp off");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("word accepted while the previous one is still in work");

   a_apply_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gppt_pkg::ST_APPLY && (!rsp_valid_ff || rsp_tready)) |=> rsp_valid_ff)
      else $error("finished item did not reach the result register");

endmodule
